// ----- rtl/lbt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbt_pkg
// Shared constants, request and status codes, controller/datapath
// interface structs and field conversion helpers for the buffer table.
// ----------------------------------------------------------------------------
package lbt_pkg;

   localparam int BUFFER_ENTRIES   = 32;
   localparam int DISK_BLOCK_COUNT = 8192;
   localparam int AGE_BITS         = 16;

   localparam int SLOT_BITS  = (BUFFER_ENTRIES > 1) ? $clog2(BUFFER_ENTRIES) : 1;
   localparam int BLOCK_BITS = $clog2(DISK_BLOCK_COUNT);

   // max-age search: first stage reduces groups of eight, second the group winners
   localparam int GROUP_SIZE  = 8;
   localparam int GROUP_COUNT = (BUFFER_ENTRIES + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int GROUP_PAD   = 1 << $clog2(GROUP_COUNT);
   localparam int PAD_ENTRIES = GROUP_PAD * GROUP_SIZE;

   // fixed field widths
   localparam int REQ_BITS       = 2;
   localparam int BLOCK_NUM_BITS = 16;
   localparam int STATUS_BITS    = 2;
   localparam int INDEX_BITS     = 5;
   localparam int WB_BLOCK_BITS  = 13;

   localparam logic [REQ_BITS-1:0] REQ_ALLOC   = 2'd0;
   localparam logic [REQ_BITS-1:0] REQ_LOOKUP  = 2'd1;
   localparam logic [REQ_BITS-1:0] REQ_DIRTY   = 2'd2;
   localparam logic [REQ_BITS-1:0] REQ_UNKNOWN = 2'd3;

   localparam logic [STATUS_BITS-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_BOUND   = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_MISSING = 2'd2;

   typedef struct packed {
      logic capture;  // latch the request
      logic exec;     // answer lookup-style requests, age slots for allocate
      logic scan;     // register group winners and free slot
      logic finish;   // pick slot, write it, answer
   } lbt_cmd_type;

   typedef struct packed {
      logic alloc_ok; // latched request is an in-bound allocate
   } lbt_stat_type;

   function automatic logic [INDEX_BITS-1:0] to_index_field(input logic [SLOT_BITS-1:0] slot);
      logic [SLOT_BITS+INDEX_BITS-1:0] ext;
      ext = {{INDEX_BITS{1'b0}}, slot};
      return ext[INDEX_BITS-1:0];
   endfunction

   function automatic logic [WB_BLOCK_BITS-1:0] to_wb_field(input logic [BLOCK_BITS-1:0] blk);
      logic [BLOCK_BITS+WB_BLOCK_BITS-1:0] ext;
      ext = {{WB_BLOCK_BITS{1'b0}}, blk};
      return ext[WB_BLOCK_BITS-1:0];
   endfunction

endpackage

// ----- rtl/lru_buffer_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_buffer_table
// Buffer-slot table with age-based LRU replacement: allocate, lookup and
// mark-dirty requests, one registered result per request.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Its result appears
// on the rsp_ ports for exactly one cycle, flagged by rsp_valid, and must be
// taken in that cycle since the block cannot hold it. Lookup, mark-dirty,
// out-of-bound and unknown requests pass through the execute state only: the
// result is registered there, and busy is already low in the cycle it shows,
// so the next request can transfer alongside it. An in-bound allocate steps
// through execute to age the used slots, scan for the first stage of the
// registered max-age tree with the free-slot search, and finish for the final
// tree stage, slot write and result. The table resets to all slots free.
module lru_buffer_table import lbt_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [REQ_BITS-1:0]       req_type,
   input  logic [BLOCK_NUM_BITS-1:0] req_block_num,
   output logic                      rsp_valid,
   output logic [STATUS_BITS-1:0]    rsp_status,
   output logic [INDEX_BITS-1:0]     rsp_slot_index,
   output logic                      rsp_writeback,
   output logic [WB_BLOCK_BITS-1:0]  rsp_writeback_block
);

   lbt_cmd_type  cmd;
   lbt_stat_type stat;

   lbt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   lbt_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_type            (req_type),
      .req_block_num       (req_block_num),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_slot_index      (rsp_slot_index),
      .rsp_writeback       (rsp_writeback),
      .rsp_writeback_block (rsp_writeback_block)
   );

`ifndef SYNTHESIS
   // a result only follows a cycle of work
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a request in flight");

   // an accepted request keeps the block busy for the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not start work");

   // one result per request, never on consecutive cycles
   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result repeated");

   // error results carry no slot and no writeback
   a_error_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STATUS_OK)) |->
         (rsp_slot_index == '0) && !rsp_writeback && (rsp_writeback_block == '0))
      else $error("error result with nonzero fields");
`endif

endmodule

// ----- rtl/lbt_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbt_ctrl
// Sequencer for the buffer table: accepts a request and steps the datapath
// through execute, and for an in-bound allocate on to max-age scan and finish.
// ----------------------------------------------------------------------------
module lbt_ctrl import lbt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  lbt_stat_type stat,
   output lbt_cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_EXEC   = 2'd1;
   localparam logic [1:0] ST_SCAN   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.capture = start;
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = stat.alloc_ok ? ST_SCAN : ST_IDLE;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/lbt_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbt_datapath
// Slot table registers, block match, free-slot search, two-stage max-age
// tree and the registered response.
// ----------------------------------------------------------------------------
module lbt_datapath import lbt_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  lbt_cmd_type               cmd,
   output lbt_stat_type              stat,
   input  logic [REQ_BITS-1:0]       req_type,
   input  logic [BLOCK_NUM_BITS-1:0] req_block_num,
   output logic                      rsp_valid,
   output logic [STATUS_BITS-1:0]    rsp_status,
   output logic [INDEX_BITS-1:0]     rsp_slot_index,
   output logic                      rsp_writeback,
   output logic [WB_BLOCK_BITS-1:0]  rsp_writeback_block
);

   // request
   logic [REQ_BITS-1:0]       req_type_ff;
   logic [BLOCK_NUM_BITS-1:0] req_block_ff;

   // slot table
   logic [BUFFER_ENTRIES-1:0] slot_used_ff, slot_used_in;
   logic [BUFFER_ENTRIES-1:0] slot_dirty_ff, slot_dirty_in;
   logic [AGE_BITS-1:0]       slot_age_ff [BUFFER_ENTRIES];
   logic [AGE_BITS-1:0]       slot_age_in [BUFFER_ENTRIES];
   logic [BLOCK_BITS-1:0]     slot_block_ff [BUFFER_ENTRIES];
   logic [BLOCK_BITS-1:0]     slot_block_in [BUFFER_ENTRIES];

   // scan stage
   logic [AGE_BITS-1:0]  grp_age_ff [GROUP_PAD];
   logic [AGE_BITS-1:0]  grp_age_in [GROUP_PAD];
   logic [SLOT_BITS-1:0] grp_idx_ff [GROUP_PAD];
   logic [SLOT_BITS-1:0] grp_idx_in [GROUP_PAD];
   logic                 free_any_ff, free_any_in;
   logic [SLOT_BITS-1:0] free_idx_ff, free_idx_in;

   // response
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0]   rsp_status_ff, rsp_status_in;
   logic [INDEX_BITS-1:0]    rsp_index_ff, rsp_index_in;
   logic                     rsp_wb_ff, rsp_wb_in;
   logic [WB_BLOCK_BITS-1:0] rsp_wb_block_ff, rsp_wb_block_in;

   logic                      in_bound;
   logic [BLOCK_BITS-1:0]     req_blk;
   logic [BUFFER_ENTRIES-1:0] hit;
   logic                      hit_any;
   logic [SLOT_BITS-1:0]      hit_idx;
   logic [AGE_BITS-1:0]       age_pad [PAD_ENTRIES];
   logic [SLOT_BITS-1:0]      victim_idx;
   logic [SLOT_BITS-1:0]      pick_idx;

   assign in_bound = {1'b0, req_block_ff} < (BLOCK_NUM_BITS + 1)'(DISK_BLOCK_COUNT);
   assign req_blk  = req_block_ff[BLOCK_BITS-1:0];
   assign stat.alloc_ok = in_bound && (req_type_ff == REQ_ALLOC);

   // lowest used slot that holds the block
   always_comb begin
      for (int i = 0; i < BUFFER_ENTRIES; i++) begin
         hit[i] = slot_used_ff[i] && (slot_block_ff[i] == req_blk);
      end
      hit_idx = '0;
      for (int i = BUFFER_ENTRIES - 1; i >= 0; i--) begin
         if (hit[i]) begin
            hit_idx = SLOT_BITS'(i);
         end
      end
   end
   assign hit_any = |hit;

   // lowest free slot
   always_comb begin
      free_idx_in = '0;
      for (int i = BUFFER_ENTRIES - 1; i >= 0; i--) begin
         if (!slot_used_ff[i]) begin
            free_idx_in = SLOT_BITS'(i);
         end
      end
      free_any_in = ~&slot_used_ff;
   end

   // pad entries read as age zero and never win a strict compare
   for (genvar e = 0; e < PAD_ENTRIES; e++) begin : g_pad
      if (e < BUFFER_ENTRIES) begin : g_real
         assign age_pad[e] = slot_age_ff[e];
      end else begin : g_fill
         assign age_pad[e] = '0;
      end
   end

   // first tree stage: oldest of each group, lower index kept on a tie
   always_comb begin
      logic [AGE_BITS-1:0]  t_age [GROUP_SIZE];
      logic [SLOT_BITS-1:0] t_idx [GROUP_SIZE];
      for (int g = 0; g < GROUP_PAD; g++) begin
         for (int j = 0; j < GROUP_SIZE; j++) begin
            t_age[j] = age_pad[g * GROUP_SIZE + j];
            t_idx[j] = SLOT_BITS'(g * GROUP_SIZE + j);
         end
         for (int s = 1; s < GROUP_SIZE; s = s * 2) begin
            for (int k = 0; k < GROUP_SIZE; k = k + 2 * s) begin
               if (t_age[k + s] > t_age[k]) begin
                  t_age[k] = t_age[k + s];
                  t_idx[k] = t_idx[k + s];
               end
            end
         end
         grp_age_in[g] = t_age[0];
         grp_idx_in[g] = t_idx[0];
      end
   end

   // second tree stage over the registered group winners
   always_comb begin
      logic [AGE_BITS-1:0]  v_age [GROUP_PAD];
      logic [SLOT_BITS-1:0] v_idx [GROUP_PAD];
      for (int g = 0; g < GROUP_PAD; g++) begin
         v_age[g] = grp_age_ff[g];
         v_idx[g] = grp_idx_ff[g];
      end
      for (int s = 1; s < GROUP_PAD; s = s * 2) begin
         for (int k = 0; k < GROUP_PAD; k = k + 2 * s) begin
            if (v_age[k + s] > v_age[k]) begin
               v_age[k] = v_age[k + s];
               v_idx[k] = v_idx[k + s];
            end
         end
      end
      victim_idx = v_idx[0];
   end

   assign pick_idx = free_any_ff ? free_idx_ff : victim_idx;

   // table update and response
   always_comb begin
      slot_used_in    = slot_used_ff;
      slot_dirty_in   = slot_dirty_ff;
      slot_age_in     = slot_age_ff;
      slot_block_in   = slot_block_ff;
      rsp_valid_in    = 1'b0;
      rsp_status_in   = rsp_status_ff;
      rsp_index_in    = rsp_index_ff;
      rsp_wb_in       = rsp_wb_ff;
      rsp_wb_block_in = rsp_wb_block_ff;

      if (cmd.exec) begin
         if (stat.alloc_ok) begin
            // age every used slot, saturating
            for (int i = 0; i < BUFFER_ENTRIES; i++) begin
               if (slot_used_ff[i] && (slot_age_ff[i] != {AGE_BITS{1'b1}})) begin
                  slot_age_in[i] = slot_age_ff[i] + AGE_BITS'(1);
               end
            end
         end else begin
            rsp_valid_in    = 1'b1;
            rsp_index_in    = '0;
            rsp_wb_in       = 1'b0;
            rsp_wb_block_in = '0;
            priority if (req_type_ff == REQ_UNKNOWN) begin
               rsp_status_in = STATUS_OK;
            end else if (!in_bound) begin
               rsp_status_in = STATUS_BOUND;
            end else if (!hit_any) begin
               rsp_status_in = STATUS_MISSING;
            end else begin
               rsp_status_in = STATUS_OK;
               rsp_index_in  = to_index_field(hit_idx);
               if (req_type_ff == REQ_DIRTY) begin
                  slot_dirty_in[hit_idx] = 1'b1;
               end
            end
         end
      end

      if (cmd.finish) begin
         rsp_valid_in    = 1'b1;
         rsp_status_in   = STATUS_OK;
         rsp_index_in    = to_index_field(pick_idx);
         rsp_wb_in       = !free_any_ff && slot_dirty_ff[victim_idx];
         rsp_wb_block_in = rsp_wb_in ? to_wb_field(slot_block_ff[victim_idx]) : '0;
         slot_used_in[pick_idx]  = 1'b1;
         slot_dirty_in[pick_idx] = 1'b0;
         slot_age_in[pick_idx]   = '0;
         slot_block_in[pick_idx] = req_blk;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_used_ff  <= '0;
         slot_dirty_ff <= '0;
         slot_age_ff   <= '{default: '0};
         rsp_valid_ff  <= 1'b0;
      end else begin
         slot_used_ff  <= slot_used_in;
         slot_dirty_ff <= slot_dirty_in;
         slot_age_ff   <= slot_age_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_type_ff  <= req_type;
         req_block_ff <= req_block_num;
      end
      if (cmd.scan) begin
         grp_age_ff  <= grp_age_in;
         grp_idx_ff  <= grp_idx_in;
         free_any_ff <= free_any_in;
         free_idx_ff <= free_idx_in;
      end
      slot_block_ff   <= slot_block_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_index_ff    <= rsp_index_in;
      rsp_wb_ff       <= rsp_wb_in;
      rsp_wb_block_ff <= rsp_wb_block_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_slot_index      = rsp_index_ff;
   assign rsp_writeback       = rsp_wb_ff;
   assign rsp_writeback_block = rsp_wb_block_ff;

endmodule
